>>> src/bmpse_pkg.sv
// Shared types and constants for the 24-bit BMP stream encoder.
// Used by every module of the block; depends on nothing.
package bmpse_pkg;

    localparam int DEF_MAX_DIMENSION = 8192;

    localparam int DIM_W     = 14;
    localparam int PIXEL_W   = 24;
    localparam int SIZE_W    = 32;
    localparam int STEP_W    = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [STEP_W-1:0] STEP_HDR_FIRST = 6'd0;
    localparam logic [STEP_W-1:0] STEP_PIX_B     = 6'd54;
    localparam logic [STEP_W-1:0] STEP_PIX_G     = 6'd55;
    localparam logic [STEP_W-1:0] STEP_PIX_R     = 6'd56;

    localparam logic [SIZE_W-1:0] HDR_BYTES  = 32'd54;
    localparam logic [7:0] INFO_SIZE  = 8'd40;
    localparam logic [7:0] BIT_COUNT  = 8'd24;
    localparam logic [7:0] PLANES     = 8'd1;
    localparam logic [15:0] PELS_PER_M = 16'd2835;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_M     = 8'h4d;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_dims;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               hdr;
        logic               frame_end;
        logic [1:0]         pad;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [SIZE_W-1:0]  bitmap_bytes;
    } t_item;

endpackage

>>> src/bmpse_cfg.sv
// Configuration registers of the BMP encoder with clamping to legal dimensions.
// Depends on bmpse_pkg.
module bmpse_cfg #(
    parameter int MAX_DIMENSION = bmpse_pkg::DEF_MAX_DIMENSION
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [bmpse_pkg::DIM_W-1:0] i_cfg_data,
    output bmpse_pkg::t_dims            o_dims
);
    import bmpse_pkg::*;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > 32'(MAX_DIMENSION)) begin
            res = DIM_W'(MAX_DIMENSION);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_dims.width  = eff_dim(r_width);
    assign o_dims.height = eff_dim(r_height);

endmodule

>>> src/bmpse_front.sv
// Input side of the BMP encoder: accepts pixels, tracks row and column,
// and builds one work item per pixel. Depends on bmpse_pkg.
module bmpse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmpse_pkg::t_dims  i_dims,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,
    input  logic              i_full,
    output logic              o_push,
    output bmpse_pkg::t_item  o_item
);
    import bmpse_pkg::*;

    logic             r_header_sent;
    logic [DIM_W-1:0] r_col;
    logic [DIM_W-1:0] r_row;

    logic             accept;
    logic             row_end;
    logic             frame_end;
    logic [1:0]       pad;
    logic [15:0]      stride;
    logic [29:0]      product;

    always_comb begin
        pad       = i_dims.width[1:0];
        stride    = 16'({i_dims.width, 1'b0}) + 16'(i_dims.width) + 16'(pad);
        product   = 30'(stride) * 30'(i_dims.height);
        row_end   = ({1'b0, r_col} + 15'd1) >= {1'b0, i_dims.width};
        frame_end = row_end && (({1'b0, r_row} + 15'd1) >= {1'b0, i_dims.height});
        accept    = i_s_tvalid && !i_full;
    end

    assign o_s_tready = !i_full;
    assign o_push     = accept;

    always_comb begin
        o_item.pixel        = i_s_tdata[PIXEL_W-1:0];
        o_item.hdr          = !r_header_sent;
        o_item.frame_end    = frame_end;
        o_item.pad          = row_end ? pad : 2'd0;
        o_item.width        = i_dims.width;
        o_item.height       = i_dims.height;
        o_item.bitmap_bytes = SIZE_W'(product);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_sent <= 1'b0;
            r_col         <= '0;
            r_row         <= '0;
        end else if (accept) begin
            r_header_sent <= !frame_end;
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + DIM_W'(1);
            end else begin
                r_col <= r_col + DIM_W'(1);
            end
        end
    end

endmodule

>>> src/bmpse_queue.sv
// Short item queue between the front and back of the BMP encoder.
// Depends on bmpse_pkg.
module bmpse_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bmpse_pkg::t_item i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output bmpse_pkg::t_item o_head
);
    import bmpse_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        res = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
        return res;
    endfunction

    assign o_full  = (32'(r_count) == QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

>>> src/bmpse_back.sv
// Output side of the BMP encoder: walks header, pixel and padding bytes of
// each queued item into a byte-wide output register. Depends on bmpse_pkg.
module bmpse_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  bmpse_pkg::t_item i_head,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast,
    output logic             o_m_tuser
);
    import bmpse_pkg::*;

    logic              r_first;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_eof;

    logic              emit;
    logic              is_last;
    logic [STEP_W-1:0] cur_step;
    logic [STEP_W-1:0] last_step;
    logic [SIZE_W-1:0] file_size;
    logic [7:0]        step_byte;

    always_comb begin
        cur_step  = r_first ? (i_head.hdr ? STEP_HDR_FIRST : STEP_PIX_B) : r_step;
        last_step = STEP_PIX_R + STEP_W'(i_head.pad);
        is_last   = (cur_step == last_step);
        emit      = i_head_valid && (!r_out_valid || i_m_tready);
        file_size = i_head.bitmap_bytes + HDR_BYTES;
    end

    always_comb begin
        unique case (cur_step)
            6'd0:       step_byte = CHAR_B;
            6'd1:       step_byte = CHAR_M;
            6'd2:       step_byte = file_size[7:0];
            6'd3:       step_byte = file_size[15:8];
            6'd4:       step_byte = file_size[23:16];
            6'd5:       step_byte = file_size[31:24];
            6'd10:      step_byte = HDR_BYTES[7:0];
            6'd14:      step_byte = INFO_SIZE;
            6'd18:      step_byte = i_head.width[7:0];
            6'd19:      step_byte = 8'(i_head.width[DIM_W-1:8]);
            6'd22:      step_byte = i_head.height[7:0];
            6'd23:      step_byte = 8'(i_head.height[DIM_W-1:8]);
            6'd26:      step_byte = PLANES;
            6'd28:      step_byte = BIT_COUNT;
            6'd34:      step_byte = i_head.bitmap_bytes[7:0];
            6'd35:      step_byte = i_head.bitmap_bytes[15:8];
            6'd36:      step_byte = i_head.bitmap_bytes[23:16];
            6'd37:      step_byte = i_head.bitmap_bytes[31:24];
            6'd38:      step_byte = PELS_PER_M[7:0];
            6'd39:      step_byte = PELS_PER_M[15:8];
            6'd42:      step_byte = PELS_PER_M[7:0];
            6'd43:      step_byte = PELS_PER_M[15:8];
            STEP_PIX_B: step_byte = i_head.pixel[7:0];
            STEP_PIX_G: step_byte = i_head.pixel[15:8];
            STEP_PIX_R: step_byte = i_head.pixel[23:16];
            default:    step_byte = 8'h00;
        endcase
    end

    assign o_pop = emit && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b1;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_first     <= is_last;
                r_step      <= cur_step + STEP_W'(1);
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= step_byte;
            r_out_last <= is_last;
            r_out_eof  <= is_last && i_head.frame_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_eof;

endmodule

>>> src/bmp_24bit_stream_encoder.sv
// Turns XRGB8888 pixels, given bottom row first, into a 24-bit BMP byte stream,
// one byte per cycle on the output stream while the sink is ready. A pixel
// gives three output bytes, blue, green and red; the first pixel of a frame adds
// 54 header bytes and the last pixel of a row adds zero to three padding bytes.
// That rate is set by the byte-wide output register of the back end; the front
// end keeps accepting pixels as long as its two-entry queue has room, so input
// and output stall independently. tlast marks the last byte a pixel causes and
// tuser marks the last byte of the file.
// Depends on bmpse_pkg, bmpse_cfg, bmpse_front, bmpse_queue and bmpse_back.
module bmp_24bit_stream_encoder #(
    parameter int MAX_DIMENSION = bmpse_pkg::DEF_MAX_DIMENSION
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [bmpse_pkg::DIM_W-1:0] i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // pixel_word
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // data_byte
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser    // end_of_file
);
    import bmpse_pkg::*;

    t_dims dims;
    t_item push_item;
    t_item head_item;
    logic  push;
    logic  pop;
    logic  full;
    logic  head_valid;

    bmpse_cfg #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_dims      (dims)
    );

    bmpse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dims     (dims),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_full     (full),
        .o_push     (push),
        .o_item     (push_item)
    );

    bmpse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head_item)
    );

    bmpse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_item),
        .o_pop        (pop),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_tdata    (m_axis_tdata),
        .o_m_tlast    (m_axis_tlast),
        .o_m_tuser    (m_axis_tuser)
    );

endmodule

>>> tb/bmp_24bit_stream_encoder_test.sv
// Self-checking testbench for bmp_24bit_stream_encoder: drives pixels, predicts
// the BMP byte stream (header, pixel bytes, row padding) and checks every byte.
// Depends on bmpse_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module bmp_24bit_stream_encoder_test;
    import bmpse_pkg::*;

    localparam int          MAX_DIM      = 8192;
    localparam logic [31:0] FILE_HDR_LEN = 32'd54;
    localparam logic [31:0] INFO_HDR_LEN = 32'd40;
    localparam logic [31:0] BITS_PER_PX  = 32'd24;
    localparam logic [31:0] PX_PER_METER = 32'd2835;
    localparam int          HOLD_LEN     = 300;
    localparam int          QUIET_LIMIT  = 2000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_run;
        logic       end_of_file;
    } t_bmp_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [13:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // pixel_word
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // data_byte
    logic        m_axis_tlast;
    logic        m_axis_tuser;          // end_of_file

    t_bmp_byte   expected_bytes[$];
    t_bmp_byte   want;
    int          fail_count = 0;
    int          quiet_cycles = 0;

    logic [13:0] width_reg = 14'd1;
    logic [13:0] height_reg = 14'd1;
    bit          header_sent = 1'b0;
    logic [31:0] col_count = '0;
    logic [31:0] row_count = '0;
    bit          frame_closed;

    int unsigned tx_max_gap = 0;
    int unsigned rx_max_gap = 0;
    int unsigned rx_wait = 0;
    int unsigned rx_draw;
    int unsigned hold_left = 0;
    bit          hold_kick = 1'b0;
    bit          hold_seen = 1'b0;

    bmp_24bit_stream_encoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] eff_dim(input logic [13:0] v);
        if (v == 0) return 32'd1;
        if (v > MAX_DIM) return 32'(MAX_DIM);
        return {18'd0, v};
    endfunction

    // Append the bytes one accepted pixel causes and advance the frame counters.
    function automatic bit predict_pixel(input logic [31:0] px);
        logic [31:0]              w, h, row_len, pad, img_size;
        logic [8*FILE_HDR_LEN-1:0] hdr;
        t_bmp_byte                out_bytes[$];
        bit                       row_done, frame_done;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        row_len = w * 3;
        pad = (4 - (row_len & 3)) & 3;
        if (!header_sent) begin
            img_size = (row_len + pad) * h;
            hdr = '0;
            hdr[8*0 +: 8]   = 8'h42;
            hdr[8*1 +: 8]   = 8'h4d;
            hdr[8*2 +: 32]  = img_size + FILE_HDR_LEN;
            hdr[8*10 +: 32] = FILE_HDR_LEN;
            hdr[8*14 +: 32] = INFO_HDR_LEN;
            hdr[8*18 +: 32] = w;
            hdr[8*22 +: 32] = h;
            hdr[8*26 +: 16] = 16'd1;
            hdr[8*28 +: 16] = BITS_PER_PX[15:0];
            hdr[8*34 +: 32] = img_size;
            hdr[8*38 +: 32] = PX_PER_METER;
            hdr[8*42 +: 32] = PX_PER_METER;
            for (int i = 0; i < FILE_HDR_LEN; i++)
                out_bytes.push_back('{hdr[8*i +: 8], 1'b0, 1'b0});
            header_sent = 1'b1;
        end
        out_bytes.push_back('{px[7:0], 1'b0, 1'b0});
        out_bytes.push_back('{px[15:8], 1'b0, 1'b0});
        out_bytes.push_back('{px[23:16], 1'b0, 1'b0});
        row_done = (col_count + 1) >= w;
        frame_done = row_done && ((row_count + 1) >= h);
        if (row_done) begin
            for (int i = 0; i < pad; i++)
                out_bytes.push_back('{8'h00, 1'b0, 1'b0});
            col_count = 0;
            if (frame_done) begin
                row_count = 0;
                header_sent = 1'b0;
            end else begin
                row_count = row_count + 1;
            end
        end else begin
            col_count = col_count + 1;
        end
        out_bytes[out_bytes.size()-1].last_in_run = 1'b1;
        out_bytes[out_bytes.size()-1].end_of_file = frame_done;
        foreach (out_bytes[i])
            expected_bytes.push_back(out_bytes[i]);
        return frame_done;
    endfunction

    task automatic send_pixel(input logic [31:0] px);
        int unsigned gap;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        frame_closed = predict_pixel(px);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [13:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) width_reg = value;
        else height_reg = value;
        @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [13:0] w, input logic [13:0] h);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    function automatic logic [13:0] random_dim();
        int unsigned pick;
        pick = $urandom_range(19, 0);
        if (pick == 0) return 14'd0;
        if (pick == 1) return 14'($urandom_range(16383, 8192));
        if (pick < 4) return 14'($urandom_range(24, 9));
        return 14'($urandom_range(6, 1));
    endfunction

    task automatic test_default_dims();
        tx_max_gap = 8;
        rx_max_gap <= 8;
        send_pixel(32'h0000_0000);
        send_pixel(32'hffff_ffff);
    endtask

    // Widths 1..4 give one, two, three and zero padding bytes.
    task automatic test_row_padding();
        logic [31:0] pattern[4];
        pattern = '{32'h00ff_00ff, 32'hff00_ff00, 32'h0f0f_0f0f, 32'hf0f0_f0f0};
        for (int w = 1; w <= 4; w++) begin
            set_dims(14'(w), 14'd1);
            for (int i = 0; i < w; i++)
                send_pixel(pattern[i]);
        end
    endtask

    task automatic test_zero_dims();
        set_dims(14'd0, 14'd0);
        send_pixel(32'haaaa_aaaa);
    endtask

    task automatic test_oversize_and_midframe();
        tx_max_gap = 0;
        rx_max_gap <= 0;
        set_dims(14'h3fff, 14'd8193);
        send_pixel(32'h5555_5555);
        set_dims(14'd1, 14'd1);
        send_pixel(32'h1234_5678);
        set_dims(14'd8192, 14'd8192);
        send_pixel(32'h89ab_cdef);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 14'd2);
        send_pixel(32'hdead_beef);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 14'd1);
        send_pixel(32'h0102_0304);
        send_pixel(32'hfedc_ba98);
    endtask

    // Hold the output long enough for the input side to back up.
    task automatic test_output_stall();
        set_dims(14'd3, 14'd2);
        tx_max_gap = 0;
        rx_max_gap <= 2;
        hold_kick <= ~hold_kick;
        repeat (24) send_pixel($urandom);
        wait_idle();
    endtask

    task automatic test_random_frames(input int unsigned n_items);
        int unsigned sent, n_px, cap;
        logic [13:0] w, h;
        sent = 0;
        while (sent < n_items) begin
            wait_idle();
            tx_max_gap = ($urandom_range(3, 0) == 0) ? 0 : 8;
            rx_max_gap <= ($urandom_range(3, 0) == 0) ? 0 : 8;
            w = random_dim();
            h = random_dim();
            case ($urandom_range(5, 0))
                0: write_reg(REG_IMAGE_WIDTH, w);
                1: write_reg(REG_IMAGE_HEIGHT, h);
                default: begin
                    write_reg(REG_IMAGE_WIDTH, w);
                    write_reg(REG_IMAGE_HEIGHT, h);
                end
            endcase
            cap = ($urandom_range(3, 0) == 0) ? $urandom_range(6, 1) : 80;
            if (cap > n_items - sent) cap = n_items - sent;
            n_px = 0;
            do begin
                send_pixel($urandom);
                n_px++;
            end while (!frame_closed && n_px < cap);
            sent += n_px;
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
            hold_left <= 0;
        end else if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= (hold_left == 1);
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_draw = $urandom_range(rx_max_gap, 0);
            rx_wait <= rx_draw;
            m_axis_tready <= (rx_draw == 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected transaction: data_byte %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want.data_byte) begin
                    $error("data_byte: expected %h, actual %h", want.data_byte, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last_in_run) begin
                    $error("last_in_run: expected %b, actual %b",
                           want.last_in_run, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser !== want.end_of_file) begin
                    $error("end_of_file: expected %b, actual %b",
                           want.end_of_file, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bmp_24bit_stream_encoder_test failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_dims();
        test_row_padding();
        test_zero_dims();
        test_oversize_and_midframe();
        test_output_stall();
        test_random_frames(330);
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_bytes.size() == 0) begin
            $display("bmp_24bit_stream_encoder_test passed");
        end else begin
            $display("bmp_24bit_stream_encoder_test failed");
        end
        $finish;
    end

endmodule
